// ===== rtl/ct_pkg.sv =====
// shared types and constants for the connection table
package ct_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned KIND_W      = 2;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned HANDLE_W    = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_FREE   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_CLOSED   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  localparam logic [DIR_W-1:0] DIR_INCOMING = 2'd1;
  localparam logic [DIR_W-1:0] DIR_OUTGOING = 2'd2;

  typedef struct packed {
    logic [PORT_W-1:0] local_port;
    logic [IP_W-1:0]   local_ip;
    logic [PORT_W-1:0] remote_port;
    logic [IP_W-1:0]   remote_ip;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/connection_table.sv =====
// connection table: open, lookup, close and free over a sequential entry scan
//
//   channel  dir  fields
//   s_axis   in   tuser kind, tdata direction/remote_ip/remote_port/local_ip/local_port/handle
//   m_axis   out  tdata status/entry_index
//
// open scans the in-use bits up to high_water, lookup reads one entry per cycle from the
// key ram up to high_water, and close and free do no scan; the result register loads in
// the last step of each, and the next transaction is taken in the idle state.
// no new transaction is taken until the current one has put its result in the output
// register, which a stalled m_axis holds.
// reset frees every entry and clears high_water; the key ram needs no clearing.
module connection_table #(
  parameter int unsigned ENTRIES = ct_pkg::ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // direction, remote_ip, remote_port, local_ip, local_port, handle, zero pad
  input  logic [ct_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic [ct_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status, entry_index, zero pad
  output logic [ct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned XW    = (CNT_W > ct_pkg::HANDLE_W) ? CNT_W : ct_pkg::HANDLE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_LOOK,
    S_CLOSE,
    S_FREE
  } state_e;

  state_e                            state_q;
  ct_pkg::kind_e                     kind_in;
  logic [ct_pkg::DIR_W-1:0]          dir_q;
  ct_pkg::entry_t                    key_q;
  logic [ct_pkg::HANDLE_W-1:0]       handle_q;
  logic [CNT_W-1:0]                  scan_q;
  logic [IDX_W-1:0]                  cmp_q;
  logic                              pend_q;
  logic [CNT_W-1:0]                  hw_q;
  logic [ENTRIES-1:0]                in_use_q;
  logic [ENTRIES-1:0]                dir_ok_q;
  logic                              m_valid_q;
  ct_pkg::status_e                   m_status_q;
  logic [ct_pkg::INDEX_W-1:0]        m_index_q;

  logic                              out_free;
  logic                              scan_end;
  logic [IDX_W-1:0]                  scan_idx;
  logic [IDX_W-1:0]                  h_idx;
  logic [XW-1:0]                     h_x;
  logic                              hit;
  logic                              res_load;
  logic                              ram_we;
  logic                              ram_re;
  ct_pkg::entry_t                    rd_entry;

  assign kind_in  = ct_pkg::kind_e'(s_axis_tuser);
  assign out_free = !m_valid_q || m_axis_tready;
  assign scan_end = (scan_q == hw_q);
  assign scan_idx = scan_q[IDX_W-1:0];
  assign h_idx    = IDX_W'(handle_q);
  assign h_x      = XW'(handle_q);

  assign hit = pend_q && in_use_q[cmp_q] && dir_ok_q[cmp_q]
            && (rd_entry.remote_ip == key_q.remote_ip)
            && (rd_entry.local_port == key_q.local_port)
            && (rd_entry.remote_port == key_q.remote_port);

  // result register loads in the last cycle of each operation
  assign res_load = out_free
                 && (((state_q == S_OPEN) && (scan_end || !in_use_q[scan_idx]))
                  || ((state_q == S_LOOK) && (hit || scan_end))
                  || (state_q == S_CLOSE)
                  || (state_q == S_FREE));

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (state_q == S_OPEN && out_free) begin
      ram_we = scan_end ? (hw_q != CNT_W'(ENTRIES)) : !in_use_q[scan_idx];
    end
    if (state_q == S_LOOK) begin
      ram_re = !hit && !scan_end;
    end
  end

  ct_ram #(
    .WIDTH (ct_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (scan_idx),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (scan_idx),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_q     <= '0;
      cmp_q      <= '0;
      pend_q     <= 1'b0;
      hw_q       <= '0;
      in_use_q   <= '0;
      dir_ok_q   <= '0;
      m_valid_q  <= 1'b0;
      m_status_q <= ct_pkg::ST_OK;
      m_index_q  <= '0;
    end else begin
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dir_q    <= s_axis_tdata[1:0];
            key_q    <= {s_axis_tdata[97:82], s_axis_tdata[81:50],
                         s_axis_tdata[49:34], s_axis_tdata[33:2]};
            handle_q <= s_axis_tdata[101:98];
            scan_q   <= '0;
            pend_q   <= 1'b0;
            unique case (kind_in)
              ct_pkg::KIND_OPEN:   state_q <= S_OPEN;
              ct_pkg::KIND_LOOKUP: state_q <= S_LOOK;
              ct_pkg::KIND_CLOSE:  state_q <= S_CLOSE;
              ct_pkg::KIND_FREE:   state_q <= S_FREE;
              default:             state_q <= S_IDLE;
            endcase
          end
        end
        S_OPEN: begin
          if (out_free) begin
            if (scan_end && hw_q == CNT_W'(ENTRIES)) begin
              m_status_q <= ct_pkg::ST_FULL;
              m_index_q  <= '0;
              state_q    <= S_IDLE;
            end else if (scan_end || !in_use_q[scan_idx]) begin
              in_use_q[scan_idx] <= 1'b1;
              dir_ok_q[scan_idx] <= (dir_q == ct_pkg::DIR_INCOMING)
                                 || (dir_q == ct_pkg::DIR_OUTGOING);
              if (scan_end) begin
                hw_q <= hw_q + 1'b1;
              end
              m_status_q <= ct_pkg::ST_OK;
              m_index_q  <= ct_pkg::INDEX_W'(scan_idx);
              state_q    <= S_IDLE;
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end
        end
        S_LOOK: begin
          if (hit) begin
            if (out_free) begin
              m_status_q <= ct_pkg::ST_OK;
              m_index_q  <= ct_pkg::INDEX_W'(cmp_q);
              state_q    <= S_IDLE;
            end
          end else if (scan_end) begin
            if (out_free) begin
              m_status_q <= ct_pkg::ST_NOTFOUND;
              m_index_q  <= '0;
              state_q    <= S_IDLE;
            end
          end else begin
            cmp_q  <= scan_idx;
            pend_q <= 1'b1;
            scan_q <= scan_q + 1'b1;
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            m_index_q <= '0;
            state_q   <= S_IDLE;
            if (h_x >= XW'(hw_q)) begin
              m_status_q <= ct_pkg::ST_INVALID;
            end else if (!in_use_q[h_idx]) begin
              m_status_q <= ct_pkg::ST_CLOSED;
            end else begin
              in_use_q[h_idx] <= 1'b0;
              m_status_q      <= ct_pkg::ST_OK;
            end
          end
        end
        S_FREE: begin
          if (out_free) begin
            if (h_x < XW'(ENTRIES)) begin
              in_use_q[h_idx] <= 1'b0;
            end
            m_status_q <= ct_pkg::ST_OK;
            m_index_q  <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_index_q, m_status_q};

endmodule

// ===== rtl/ct_ram.sv =====
// generic single-port-write ram with registered read
module ct_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== tb/testbench.sv =====
// testbench for the connection table: directed and random transactions against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_ENTRIES = ct_pkg::ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    ct_pkg::status_e                status;
    logic [ct_pkg::INDEX_W-1:0]     index;
  } reply_t;

  class conn_table_model;
    bit                          in_use [TBL_ENTRIES];
    logic [ct_pkg::DIR_W-1:0]    dir    [TBL_ENTRIES];
    logic [ct_pkg::IP_W-1:0]     rip    [TBL_ENTRIES];
    logic [ct_pkg::PORT_W-1:0]   rport  [TBL_ENTRIES];
    logic [ct_pkg::IP_W-1:0]     lip    [TBL_ENTRIES];
    logic [ct_pkg::PORT_W-1:0]   lport  [TBL_ENTRIES];
    int unsigned                 high_water;
    reply_t                      expected_replies [$];
    int unsigned                 mismatches;

    function new();
      for (int i = 0; i < TBL_ENTRIES; i++) begin
        in_use[i] = 1'b0;
        dir[i]    = '0;
        rip[i]    = '0;
        rport[i]  = '0;
        lip[i]    = '0;
        lport[i]  = '0;
      end
      high_water = 0;
      mismatches = 0;
    endfunction

    function void entry_key(input int unsigned i, output logic [ct_pkg::IP_W-1:0] r_ip,
                            output logic [ct_pkg::PORT_W-1:0] r_port,
                            output logic [ct_pkg::PORT_W-1:0] l_port);
      r_ip   = rip[i];
      r_port = rport[i];
      l_port = lport[i];
    endfunction

    function void note_request(input logic [ct_pkg::KIND_W-1:0] kind_bits,
                               input logic [ct_pkg::IN_TDATA_W-1:0] td);
      logic [ct_pkg::DIR_W-1:0]    q_dir;
      logic [ct_pkg::IP_W-1:0]     q_rip;
      logic [ct_pkg::PORT_W-1:0]   q_rport;
      logic [ct_pkg::IP_W-1:0]     q_lip;
      logic [ct_pkg::PORT_W-1:0]   q_lport;
      logic [ct_pkg::HANDLE_W-1:0] q_handle;
      int unsigned                 slot;
      bit                          found;
      reply_t                      r;
      q_dir    = td[1:0];
      q_rip    = td[33:2];
      q_rport  = td[49:34];
      q_lip    = td[81:50];
      q_lport  = td[97:82];
      q_handle = td[101:98];
      r.status = ct_pkg::ST_OK;
      r.index  = '0;
      case (ct_pkg::kind_e'(kind_bits))
        ct_pkg::KIND_OPEN: begin
          found = 1'b0;
          slot  = 0;
          for (int i = 0; i < high_water; i++) begin
            if (!found && !in_use[i]) begin
              found = 1'b1;
              slot  = i;
            end
          end
          if (!found && high_water >= TBL_ENTRIES) begin
            r.status = ct_pkg::ST_FULL;
          end else begin
            if (!found) begin
              slot = high_water;
              high_water++;
            end
            in_use[slot] = 1'b1;
            dir[slot]    = q_dir;
            rip[slot]    = q_rip;
            rport[slot]  = q_rport;
            lip[slot]    = q_lip;
            lport[slot]  = q_lport;
            r.index      = slot[ct_pkg::INDEX_W-1:0];
          end
        end
        ct_pkg::KIND_LOOKUP: begin
          found = 1'b0;
          for (int i = 0; i < high_water; i++) begin
            if (!found && in_use[i] &&
                (dir[i] == ct_pkg::DIR_INCOMING || dir[i] == ct_pkg::DIR_OUTGOING) &&
                rip[i] == q_rip && lport[i] == q_lport && rport[i] == q_rport) begin
              found   = 1'b1;
              r.index = i[ct_pkg::INDEX_W-1:0];
            end
          end
          if (!found) r.status = ct_pkg::ST_NOTFOUND;
        end
        ct_pkg::KIND_CLOSE: begin
          if (q_handle >= high_water) begin
            r.status = ct_pkg::ST_INVALID;
          end else if (!in_use[q_handle]) begin
            r.status = ct_pkg::ST_CLOSED;
          end else begin
            in_use[q_handle] = 1'b0;
          end
        end
        default: begin
          in_use[q_handle] = 1'b0;
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(input logic [ct_pkg::OUT_TDATA_W-1:0] td);
      reply_t exp_r;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: status %0d index %0d", td[2:0], td[6:3]);
      end else begin
        exp_r = expected_replies.pop_front();
        if (td[2:0] !== exp_r.status || td[6:3] !== exp_r.index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d index %0d, got status %0d index %0d",
                     exp_r.status, exp_r.index, td[2:0], td[6:3]);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ct_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [ct_pkg::KIND_W-1:0]      s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [ct_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  conn_table_model table_model;
  int unsigned     burst_left;
  int unsigned     idle_cycles;
  int unsigned     stall_cnt;
  int unsigned     stall_mode;
  logic [ct_pkg::IP_W-1:0]   ip_pool   [4];
  logic [ct_pkg::PORT_W-1:0] port_pool [4];

  connection_table #(.ENTRIES(TBL_ENTRIES)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver stall pattern, mode picked at random from four
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_cnt[1:0] == 2'd0);
      default: m_axis_tready <= (stall_cnt[5:3] != 3'd0);
    endcase
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) table_model.check_reply(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) table_model.note_request(s_axis_tuser, s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input ct_pkg::kind_e k, input logic [ct_pkg::DIR_W-1:0] d,
                           input logic [ct_pkg::IP_W-1:0] r_ip,
                           input logic [ct_pkg::PORT_W-1:0] r_port,
                           input logic [ct_pkg::IP_W-1:0] l_ip,
                           input logic [ct_pkg::PORT_W-1:0] l_port,
                           input logic [ct_pkg::HANDLE_W-1:0] h);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {2'b00, h, l_port, l_ip, r_port, r_ip, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_open(input logic [ct_pkg::DIR_W-1:0] d, input logic [ct_pkg::IP_W-1:0] r_ip,
                           input logic [ct_pkg::PORT_W-1:0] r_port,
                           input logic [ct_pkg::IP_W-1:0] l_ip,
                           input logic [ct_pkg::PORT_W-1:0] l_port);
    send_item(ct_pkg::KIND_OPEN, d, r_ip, r_port, l_ip, l_port, ct_pkg::HANDLE_W'($urandom));
  endtask

  task automatic send_lookup(input logic [ct_pkg::IP_W-1:0] r_ip,
                             input logic [ct_pkg::PORT_W-1:0] r_port,
                             input logic [ct_pkg::PORT_W-1:0] l_port);
    send_item(ct_pkg::KIND_LOOKUP, ct_pkg::DIR_W'($urandom), r_ip, r_port, $urandom, l_port,
              ct_pkg::HANDLE_W'($urandom));
  endtask

  task automatic send_release(input ct_pkg::kind_e k, input logic [ct_pkg::HANDLE_W-1:0] h);
    send_item(k, ct_pkg::DIR_W'($urandom), $urandom, ct_pkg::PORT_W'($urandom), $urandom,
              ct_pkg::PORT_W'($urandom), h);
  endtask

  task automatic run_directed();
    send_lookup('0, '0, '0);
    send_release(ct_pkg::KIND_CLOSE, 4'd0);
    send_release(ct_pkg::KIND_FREE, 4'd15);
    send_open(ct_pkg::DIR_INCOMING, '0, '0, '0, '0);
    send_open(ct_pkg::DIR_OUTGOING, '1, '1, '1, '1);
    send_open(2'd0, 32'h0a00_0001, 16'h1234, 32'hc0a8_0001, 16'h0050);
    send_open(2'd3, 32'h0a00_0001, 16'h1234, 32'hc0a8_0001, 16'h0050);
    send_lookup('0, '0, '0);
    send_lookup('1, '1, '1);
    send_lookup(32'h0a00_0001, 16'h1234, 16'h0050);
    send_open(ct_pkg::DIR_INCOMING, 32'h0a00_0001, 16'h1234, 32'h5555_aaaa, 16'h0050);
    send_open(ct_pkg::DIR_OUTGOING, 32'h0a00_0001, 16'h1234, 32'haaaa_5555, 16'h0050);
    send_lookup(32'h0a00_0001, 16'h1234, 16'h0050);
    send_lookup(32'h0a00_0001, 16'h1234, 16'h0051);
    send_release(ct_pkg::KIND_CLOSE, 4'd1);
    send_release(ct_pkg::KIND_CLOSE, 4'd1);
    send_lookup('1, '1, '1);
    send_release(ct_pkg::KIND_CLOSE, 4'd6);
    send_release(ct_pkg::KIND_FREE, 4'd0);
    send_lookup('0, '0, '0);
    // refill and run into the full table
    for (int i = 0; i < 13; i++)
      send_open(ct_pkg::DIR_INCOMING + ct_pkg::DIR_W'(i % 2), $urandom,
                ct_pkg::PORT_W'($urandom), $urandom, ct_pkg::PORT_W'($urandom));
    send_release(ct_pkg::KIND_CLOSE, 4'd15);
    send_release(ct_pkg::KIND_CLOSE, 4'd15);
  endtask

  task automatic run_random();
    int unsigned                 phase_left;
    int unsigned                 open_w;
    int unsigned                 roll;
    int unsigned                 hw;
    logic [ct_pkg::IP_W-1:0]     r_ip;
    logic [ct_pkg::PORT_W-1:0]   r_port;
    logic [ct_pkg::PORT_W-1:0]   l_port;
    logic [ct_pkg::DIR_W-1:0]    d;
    logic [ct_pkg::HANDLE_W-1:0] h;
    phase_left = 0;
    open_w = 40;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 150);
        case ($urandom_range(0, 2))
          0: open_w = 70;
          1: open_w = 40;
          default: open_w = 15;
        endcase
      end
      phase_left--;
      hw = table_model.high_water;
      roll = $urandom_range(0, 99);
      if (roll < open_w) begin
        d = ($urandom_range(0, 9) == 0)
              ? ($urandom_range(0, 1) ? 2'd0 : 2'd3)
              : ct_pkg::DIR_W'($urandom_range(ct_pkg::DIR_INCOMING, ct_pkg::DIR_OUTGOING));
        r_ip   = $urandom_range(0, 1) ? ip_pool[$urandom_range(0, 3)] : $urandom;
        r_port = $urandom_range(0, 1) ? port_pool[$urandom_range(0, 3)]
                                      : ct_pkg::PORT_W'($urandom);
        l_port = $urandom_range(0, 1) ? port_pool[$urandom_range(0, 3)]
                                      : ct_pkg::PORT_W'($urandom);
        send_open(d, r_ip, r_port, $urandom, l_port);
      end else if (roll < open_w + (100 - open_w) / 2) begin
        if (hw > 0 && $urandom_range(0, 9) < 7) begin
          table_model.entry_key($urandom_range(0, hw - 1), r_ip, r_port, l_port);
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
              0: r_ip[$urandom_range(0, ct_pkg::IP_W - 1)] ^= 1'b1;
              1: r_port[$urandom_range(0, ct_pkg::PORT_W - 1)] ^= 1'b1;
              default: l_port[$urandom_range(0, ct_pkg::PORT_W - 1)] ^= 1'b1;
            endcase
          end
        end else begin
          r_ip   = $urandom_range(0, 1) ? ip_pool[$urandom_range(0, 3)] : $urandom;
          r_port = $urandom_range(0, 1) ? port_pool[$urandom_range(0, 3)]
                                        : ct_pkg::PORT_W'($urandom);
          l_port = $urandom_range(0, 1) ? port_pool[$urandom_range(0, 3)]
                                        : ct_pkg::PORT_W'($urandom);
        end
        send_lookup(r_ip, r_port, l_port);
      end else begin
        h = ($urandom_range(0, 4) != 0 && hw > 0) ? ct_pkg::HANDLE_W'($urandom_range(0, hw - 1))
                                                  : ct_pkg::HANDLE_W'($urandom);
        send_release($urandom_range(0, 3) != 0 ? ct_pkg::KIND_CLOSE : ct_pkg::KIND_FREE, h);
      end
    end
  endtask

  initial begin
    table_model   = new();
    burst_left    = 0;
    idle_cycles   = 0;
    stall_cnt     = 0;
    stall_mode    = 0;
    for (int i = 0; i < 4; i++) begin
      ip_pool[i]   = $urandom;
      port_pool[i] = ct_pkg::PORT_W'($urandom);
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ct_pkg::KIND_OPEN;
    m_axis_tready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (table_model.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (table_model.mismatches == 0 && table_model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ct_pkg.sv
rtl/ct_ram.sv
rtl/connection_table.sv
tb/testbench.sv
